[sv/tcca_pkg.sv]
// Package: types, constants and helpers for the checked text-command ALU.
`timescale 1ns / 1ps
package tcca_pkg;
    localparam int MaxTextLengthDefault = 1000;
    localparam int QueueDepth = 2;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_EMPTY    = 4'd1,
        ST_TOO_LONG = 4'd2,
        ST_TOKENS   = 4'd3,
        ST_BAD_A    = 4'd4,
        ST_BAD_B    = 4'd5,
        ST_ADD_OVF  = 4'd6,
        ST_SUB_OVF  = 4'd7,
        ST_MUL_OVF  = 4'd8,
        ST_DIV_ERR  = 4'd9,
        ST_BAD_OP   = 4'd10
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [23:0] OpcAdd = 24'h414444;
    localparam logic [23:0] OpcSub = 24'h535542;
    localparam logic [23:0] OpcMul = 24'h4D554C;
    localparam logic [23:0] OpcDiv = 24'h444956;

    localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MagLimit = 64'd922337203685477580;

    // Classified request from front end to back end.
    typedef struct packed {
        logic        pre_err;
        status_t     status;
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
    } job_t;
endpackage

[sv/tcca_if.sv]
// Valid/ready channel interfaces for the ALU input and result.
`timescale 1ns / 1ps
interface tcca_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_byte;
    modport source (output valid, func, char_byte, input ready);
    modport sink (input valid, func, char_byte, output ready);
endinterface

interface tcca_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         status;
    logic signed [63:0] result_value;
    modport source (output valid, status, result_value, input ready);
    modport sink (input valid, status, result_value, output ready);
endinterface

[sv/text_command_checked_alu_core.sv]
// Top level: checked text-command ALU with decoupled parser and executor.
// Throughput: one command byte per cycle; the end request of a command
// waits while the two-entry job queue is full; multiply uses a 32x32 unit,
// divide a radix-2 restoring loop.
// Reset: asynchronous active-low, clears parser state, queue and result valid.
`timescale 1ns / 1ps
module text_command_checked_alu_core
    import tcca_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = MaxTextLengthDefault
) (
    input logic      clk,
    input logic      rst_n,
    tcca_in_if.sink  in_ch,
    tcca_out_if.source out_ch
);
    job_t fq_job, qb_job;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    logic [63:0] res_val;

    tcca_front #(.MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .func(in_ch.func), .char_byte(in_ch.char_byte),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    tcca_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
    );

    tcca_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready),
        .status(out_ch.status), .result_value(res_val)
    );

    assign out_ch.result_value = res_val;

    a_nonzero_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.result_value == 64'sd0)
        else $error("nonzero value on error status");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status <= ST_BAD_OP)
        else $error("status out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
        else $error("result dropped");
endmodule

[sv/tcca_front.sv]
// Front end: tokenizes the command text and classifies it into a job.
`timescale 1ns / 1ps
module tcca_front
    import tcca_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = MaxTextLengthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] char_byte,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);
    localparam int LenW = $clog2(MAX_TEXT_LENGTH + 2);

    logic [LenW-1:0] text_length_reg, text_length_next;
    logic            started_reg, started_next;
    logic            inside_token_reg, inside_token_next;
    logic [2:0]      token_count_reg, token_count_next;
    logic [23:0]     op_letters_reg, op_letters_next;
    logic [2:0]      op_length_reg, op_length_next;
    logic [63:0]     mag_reg [2];
    logic [63:0]     mag_next [2];
    logic [4:0]      flags_reg [2];
    logic [4:0]      flags_next [2];

    logic       is_space;
    logic [7:0] upper;
    logic       fire;
    logic [3:0] digit;
    logic       num_ok [2];
    logic [63:0] num_val [2];
    logic       in_num;
    logic       k;

    assign in_ready = !func || job_ready;
    assign fire = in_valid && in_ready;
    assign job_valid = in_valid && func;
    assign is_space = (char_byte == 8'd32) || (char_byte >= 8'd9 && char_byte <= 8'd13);
    assign upper = (char_byte >= 8'h61 && char_byte <= 8'h7A) ? char_byte - 8'd32 : char_byte;
    assign digit = char_byte[3:0];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            num_ok[i] = !(flags_reg[i][3] || flags_reg[i][4]) && flags_reg[i][2] &&
                        (flags_reg[i][0] ? mag_reg[i] <= SignBit : mag_reg[i] < SignBit);
            num_val[i] = flags_reg[i][0] ? 64'd0 - mag_reg[i] : mag_reg[i];
        end
    end

    always_comb
    begin
        job = '0;
        job.a = num_val[0];
        job.b = num_val[1];
        job.op = OP_ADD;
        job.pre_err = 1'b1;
        job.status = ST_OK;
        if (!started_reg)
            job.status = ST_EMPTY;
        else if (text_length_reg > LenW'(MAX_TEXT_LENGTH))
            job.status = ST_TOO_LONG;
        else if (token_count_reg != 3'd3)
            job.status = ST_TOKENS;
        else if (!num_ok[0])
            job.status = ST_BAD_A;
        else if (!num_ok[1])
            job.status = ST_BAD_B;
        else if (op_length_reg != 3'd3)
            job.status = ST_BAD_OP;
        else if (op_letters_reg == OpcAdd)
        begin
            job.pre_err = 1'b0;
            job.op = OP_ADD;
        end
        else if (op_letters_reg == OpcSub)
        begin
            job.pre_err = 1'b0;
            job.op = OP_SUB;
        end
        else if (op_letters_reg == OpcMul)
        begin
            job.pre_err = 1'b0;
            job.op = OP_MUL;
        end
        else if (op_letters_reg == OpcDiv)
        begin
            job.pre_err = 1'b0;
            job.op = OP_DIV;
        end
        else
            job.status = ST_BAD_OP;
    end

    always_comb
    begin
        text_length_next  = text_length_reg;
        started_next      = started_reg;
        inside_token_next = inside_token_reg;
        token_count_next  = token_count_reg;
        op_letters_next   = op_letters_reg;
        op_length_next    = op_length_reg;
        mag_next          = mag_reg;
        flags_next        = flags_reg;
        in_num            = 1'b0;
        k                 = 1'b0;
        if (func)
        begin
            text_length_next  = '0;
            started_next      = 1'b0;
            inside_token_next = 1'b0;
            token_count_next  = '0;
            op_letters_next   = '0;
            op_length_next    = '0;
            mag_next[0] = '0;
            mag_next[1] = '0;
            flags_next[0] = '0;
            flags_next[1] = '0;
        end
        else if (started_reg || !is_space)
        begin
            started_next = 1'b1;
            if (text_length_reg <= LenW'(MAX_TEXT_LENGTH))
                text_length_next = text_length_reg + 1'b1;
            if (is_space)
                inside_token_next = 1'b0;
            else
            begin
                inside_token_next = 1'b1;
                if (!inside_token_reg && token_count_reg < 3'd4)
                    token_count_next = token_count_reg + 1'b1;
                if (token_count_next == 3'd1)
                begin
                    if (op_length_reg < 3'd3)
                        op_letters_next = op_letters_reg |
                            ({16'd0, upper} << (5'd8 * (5'd2 - {3'd0, op_length_reg[1:0]})));
                    if (op_length_reg < 3'd4)
                        op_length_next = op_length_reg + 1'b1;
                end
                else if (token_count_next == 3'd2 || token_count_next == 3'd3)
                begin
                    in_num = 1'b1;
                    k = (token_count_next == 3'd3);
                end
            end
        end
        if (in_num)
        begin
            if (char_byte == 8'h2B || char_byte == 8'h2D)
            begin
                if (flags_reg[k][1] || flags_reg[k][2])
                    flags_next[k][3] = 1'b1;
                else
                begin
                    flags_next[k][1] = 1'b1;
                    flags_next[k][0] = (char_byte == 8'h2D);
                end
            end
            else if (char_byte >= 8'h30 && char_byte <= 8'h39)
            begin
                flags_next[k][2] = 1'b1;
                if (!flags_reg[k][4])
                begin
                    if (mag_reg[k] > MagLimit || (mag_reg[k] == MagLimit && digit > 4'd8))
                        flags_next[k][4] = 1'b1;
                    else
                        mag_next[k] = {mag_reg[k][60:0], 3'b000} + {mag_reg[k][62:0], 1'b0}
                                      + {60'd0, digit};
                end
            end
            else
                flags_next[k][3] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_length_reg  <= '0;
            started_reg      <= 1'b0;
            inside_token_reg <= 1'b0;
            token_count_reg  <= '0;
            op_letters_reg   <= '0;
            op_length_reg    <= '0;
            mag_reg[0] <= '0;
            mag_reg[1] <= '0;
            flags_reg[0] <= '0;
            flags_reg[1] <= '0;
        end
        else if (fire)
        begin
            text_length_reg  <= text_length_next;
            started_reg      <= started_next;
            inside_token_reg <= inside_token_next;
            token_count_reg  <= token_count_next;
            op_letters_reg   <= op_letters_next;
            op_length_reg    <= op_length_next;
            mag_reg    <= mag_next;
            flags_reg  <= flags_next;
        end
    end
endmodule

[sv/tcca_queue.sv]
// Small job queue between front and back ends.
`timescale 1ns / 1ps
module tcca_queue
    import tcca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);
    job_t       mem_reg [QueueDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'(QueueDepth);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end
endmodule

[sv/tcca_back.sv]
// Back end: checked add/sub, multi-cycle multiply and restoring divide.
`timescale 1ns / 1ps
module tcca_back
    import tcca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [3:0]  status,
    output logic [63:0] result_value
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg;
    op_t         op_reg;
    logic [1:0]  pa_reg;
    logic [1:0]  pb_reg;
    logic [127:0] acc_reg;
    logic [63:0] quo_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic        out_valid_reg;
    logic [3:0]  out_status_reg;
    logic [63:0] out_value_reg;

    logic [63:0] a_mag, b_mag, sum, dif;
    logic        sa, sb;
    logic [63:0] pp;
    logic [127:0] pp_shift;
    logic [64:0] rem_try;
    logic [63:0] rem_sh;
    logic        take;
    logic [63:0] prod_lo;
    logic        prod_hi_nz;

    assign sa = job.a[63];
    assign sb = job.b[63];
    assign a_mag = sa ? 64'd0 - job.a : job.a;
    assign b_mag = sb ? 64'd0 - job.b : job.b;
    assign sum = job.a + job.b;
    assign dif = job.a - job.b;

    assign job_ready = (state_reg == S_IDLE) && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign status = out_status_reg;
    assign result_value = out_value_reg;

    // 32x32 partial product per cycle
    assign pp = (pa_reg[0] ? ma_reg[63:32] : ma_reg[31:0]) *
                (pb_reg[0] ? mb_reg[63:32] : mb_reg[31:0]);
    assign pp_shift = {64'd0, pp} << (7'd32 * ({6'd0, pa_reg[0]} + {6'd0, pb_reg[0]}));

    assign rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign rem_try = {rem_reg, quo_reg[63]} - {1'b0, mb_reg};
    assign take = !rem_try[64];
    assign prod_lo = acc_reg[63:0];
    assign prod_hi_nz = |acc_reg[127:64];

    always_comb
    begin
        unique case (state_reg)
            S_IDLE: state_next = S_IDLE;
            S_MUL:  state_next = (pa_reg == 2'd3) ? S_FIN : S_MUL;
            S_DIV:  state_next = (cnt_reg == 6'd63) ? S_FIN : S_DIV;
            S_FIN:  state_next = (!out_valid_reg || res_ready) ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && job_valid && job_ready && !job.pre_err &&
            (job.op == OP_MUL || job.op == OP_DIV) &&
            !(job.op == OP_MUL && (a_mag == 64'd0 || b_mag == 64'd0)) &&
            !(job.op == OP_DIV && (b_mag == 64'd0 || (job.a == SignBit && job.b == '1))))
            state_next = (job.op == OP_MUL) ? S_MUL : S_DIV;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid && job_ready)
        begin
            ma_reg  <= a_mag;
            mb_reg  <= b_mag;
            neg_reg <= sa != sb;
            op_reg  <= job.op;
            pa_reg  <= 2'd0;
            pb_reg  <= 2'd0;
            acc_reg <= '0;
            quo_reg <= a_mag;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            acc_reg <= acc_reg + pp_shift;
            pa_reg  <= pa_reg + 2'd1;
            pb_reg  <= {1'b0, pa_reg[0] ^ 1'b1} ^ {1'b0, pa_reg[1] ^ pa_reg[0]};
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= take ? rem_try[63:0] : rem_sh;
            quo_reg <= {quo_reg[62:0], take};
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid && res_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE && job_valid && job_ready && state_next == S_IDLE)
                out_valid_reg <= 1'b1;
            if (state_reg == S_FIN && state_next == S_IDLE)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid && job_ready && state_next == S_IDLE)
        begin
            out_value_reg <= '0;
            if (job.pre_err)
                out_status_reg <= job.status;
            else
            begin
                unique case (job.op)
                    OP_ADD:
                        if (sa == sb && sum[63] != sa)
                            out_status_reg <= ST_ADD_OVF;
                        else
                        begin
                            out_status_reg <= ST_OK;
                            out_value_reg  <= sum;
                        end
                    OP_SUB:
                        if (sa != sb && dif[63] != sa)
                            out_status_reg <= ST_SUB_OVF;
                        else
                        begin
                            out_status_reg <= ST_OK;
                            out_value_reg  <= dif;
                        end
                    OP_MUL:
                        out_status_reg <= ST_OK;
                    OP_DIV:
                        out_status_reg <= ST_DIV_ERR;
                    default:
                        out_status_reg <= ST_OK;
                endcase
            end
        end
        else if (state_reg == S_FIN && state_next == S_IDLE)
        begin
            out_value_reg <= '0;
            if (op_reg == OP_MUL)
            begin
                if (prod_hi_nz || (neg_reg ? prod_lo > SignBit : prod_lo >= SignBit))
                    out_status_reg <= ST_MUL_OVF;
                else
                begin
                    out_status_reg <= ST_OK;
                    out_value_reg  <= neg_reg ? 64'd0 - prod_lo : prod_lo;
                end
            end
            else
            begin
                out_status_reg <= ST_OK;
                out_value_reg  <= neg_reg ? 64'd0 - quo_reg : quo_reg;
            end
        end
    end
endmodule

[verif/tcca_checker.sv]
// Checker: watches both channels, predicts ALU results and compares them.
`timescale 1ns / 1ps
module tcca_checker
    import tcca_pkg::*;
#(
    parameter int MAX_TEXT_LENGTH = MaxTextLengthDefault
) (
    input logic clk,
    input logic rst_n,
    tcca_in_if.sink in_ch,
    tcca_out_if.sink out_ch,
    output int errors,
    output int pending
);
    typedef struct {
        status_t     status;
        logic [63:0] value;
    } alu_result_t;

    localparam logic [4:0] FNeg = 5'd1, FSign = 5'd2, FDigit = 5'd4,
                           FBad = 5'd8, FRange = 5'd16;

    alu_result_t result_q[$];
    int          text_len;
    bit          started;
    bit          in_token;
    int          tok_cnt;
    logic [23:0] op_text;
    int          op_len;
    logic [63:0] mag[2];
    logic [4:0]  flags[2];

    assign pending = result_q.size();

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void clear_parse();
        text_len = 0;
        started = 0;
        in_token = 0;
        tok_cnt = 0;
        op_text = '0;
        op_len = 0;
        mag[0] = '0;
        mag[1] = '0;
        flags[0] = '0;
        flags[1] = '0;
    endfunction

    function automatic void number_char(int k, logic [7:0] c);
        logic [4:0]  f;
        logic [63:0] d;
        f = flags[k];
        d = 64'(c - 8'd48);
        if (c == "+" || c == "-")
        begin
            if ((f & (FSign | FDigit)) != 0)
                f |= FBad;
            else
                f |= FSign | ((c == "-") ? FNeg : 5'd0);
        end
        else if (c >= "0" && c <= "9")
        begin
            f |= FDigit;
            if ((f & FRange) == 0)
            begin
                if (mag[k] > MagLimit || (mag[k] == MagLimit && d > 8))
                    f |= FRange;
                else
                    mag[k] = mag[k] * 10 + d;
            end
        end
        else
            f |= FBad;
        flags[k] = f;
    endfunction

    function automatic bit operand(int k, output logic [63:0] v);
        v = '0;
        if ((flags[k] & (FBad | FRange)) != 0 || (flags[k] & FDigit) == 0)
            return 0;
        if ((flags[k] & FNeg) != 0)
        begin
            if (mag[k] > SignBit)
                return 0;
            v = -mag[k];
        end
        else
        begin
            if (mag[k] >= SignBit)
                return 0;
            v = mag[k];
        end
        return 1;
    endfunction

    function automatic alu_result_t evaluate();
        alu_result_t r;
        logic [63:0] a, b, s, ma, mb, p;
        logic [127:0] wide;
        bit          sa, sb, neg;
        r.status = ST_OK;
        r.value = '0;
        if (!started) r.status = ST_EMPTY;
        else if (text_len > MAX_TEXT_LENGTH) r.status = ST_TOO_LONG;
        else if (tok_cnt != 3) r.status = ST_TOKENS;
        else if (!operand(0, a)) r.status = ST_BAD_A;
        else if (!operand(1, b)) r.status = ST_BAD_B;
        else
        begin
            sa = a[63];
            sb = b[63];
            ma = sa ? -a : a;
            mb = sb ? -b : b;
            neg = sa != sb;
            if (op_len != 3) r.status = ST_BAD_OP;
            else if (op_text == OpcAdd)
            begin
                s = a + b;
                if (sa == sb && s[63] != sa) r.status = ST_ADD_OVF;
                else r.value = s;
            end
            else if (op_text == OpcSub)
            begin
                s = a - b;
                if (sa != sb && s[63] != sa) r.status = ST_SUB_OVF;
                else r.value = s;
            end
            else if (op_text == OpcMul)
            begin
                wide = ma * mb;
                p = wide[63:0];
                if (ma == 0 || mb == 0) r.value = '0;
                else if (wide[127:64] != 0 || (neg ? p > SignBit : p >= SignBit))
                    r.status = ST_MUL_OVF;
                else r.value = neg ? -p : p;
            end
            else if (op_text == OpcDiv)
            begin
                if (mb == 0 || (a == SignBit && b == '1)) r.status = ST_DIV_ERR;
                else
                begin
                    p = ma / mb;
                    r.value = neg ? -p : p;
                end
            end
            else r.status = ST_BAD_OP;
        end
        return r;
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic [7:0] u;
        if (!started && is_ws(c))
            return;
        started = 1;
        if (text_len <= MAX_TEXT_LENGTH)
            text_len++;
        if (is_ws(c))
        begin
            in_token = 0;
            return;
        end
        if (!in_token)
        begin
            in_token = 1;
            if (tok_cnt < 4) tok_cnt++;
        end
        if (tok_cnt == 1)
        begin
            if (op_len < 3)
            begin
                u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                op_text |= 24'(u) << (8 * (2 - op_len));
            end
            if (op_len < 4) op_len++;
        end
        else if (tok_cnt == 2) number_char(0, c);
        else if (tok_cnt == 3) number_char(1, c);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t got, want;
        if (!rst_n)
        begin
            clear_parse();
            result_q.delete();
            errors <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.func)
                begin
                    result_q.push_back(evaluate());
                    clear_parse();
                end
                else
                    take_char(in_ch.char_byte);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = status_t'(out_ch.status);
                got.value = out_ch.result_value;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d value %0d", $time,
                             got.status, $signed(got.value));
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status != want.status || got.value != want.value)
                    begin
                        $display("%0t: expected status %0d value %0d, got %0d value %0d",
                                 $time, want.status, $signed(want.value), got.status,
                                 $signed(got.value));
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_top.sv]
// Testbench top: drives ALU text commands and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import tcca_pkg::*;

    localparam int CycleLimit = 1000000;

    logic clk = 0;
    logic rst_n = 0;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   calm = 0;
    int   in_idle = 0;
    int   out_idle = 0;

    tcca_in_if  in_ch();
    tcca_out_if out_ch();

    text_command_checked_alu_core u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                         .out_ch(out_ch));
    tcca_checker u_chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                        .errors(errors), .pending(pending));

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.func = 0;
        in_ch.char_byte = 0;
        out_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!calm && out_idle == 0 && $urandom_range(0, 9) == 0)
            out_idle = $urandom_range(1, 17);
        if (out_idle > 0)
        begin
            out_idle--;
            out_ch.ready <= 0;
        end
        else
            out_ch.ready <= 1;
    end

    task automatic send(bit f, logic [7:0] c);
        if (!calm && in_idle == 0 && $urandom_range(0, 15) == 0)
            in_idle = $urandom_range(1, 17);
        while (in_idle > 0)
        begin
            in_idle--;
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= f;
        in_ch.char_byte <= c;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic command(string s);
        for (int i = 0; i < s.len(); i++)
            send(0, s[i]);
        send(1, 8'($urandom));
    endtask

    function automatic string rand_num(int kind);
        string s, d;
        int    n;
        s = "";
        case ($urandom_range(0, 3))
            0: s = "-";
            1: s = "+";
            default: s = "";
        endcase
        case (kind)
            0: n = $urandom_range(1, 3);
            1: n = $urandom_range(1, 10);
            default: n = $urandom_range(15, 21);
        endcase
        for (int i = 0; i < n; i++)
            s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 15) == 0)
            s = {s, string'(8'($urandom_range(0, 255)))};
        return s;
    endfunction

    function automatic string rand_ws();
        byte ws[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        string s;
        s = "";
        repeat ($urandom_range(1, 2))
            s = {s, string'(ws[$urandom_range(0, 5)])};
        return s;
    endfunction

    function automatic string rand_op();
        string ops[5] = '{"add", "SUB", "Mul", "dIv", "MOD"};
        string s;
        s = ops[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) s = s.toupper();
        if ($urandom_range(0, 20) == 0) s = {s, "X"};
        return s;
    endfunction

    task automatic wait_drain();
        in_ch.valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        command("");
        command(" \t\n");
        command("ADD 1 2");
        command("  sub -5 +7");
        command("MUL -3037000499 3037000499");
        command("MUL 4294967296 4294967296");
        command("div -9223372036854775808 -1");
        command("DIV 7 0");
        command("DIV -7 2");
        command("ADD 9223372036854775807 1");
        command("SUB -9223372036854775808 1");
        command("ADD -9223372036854775808 -0");
        command("ADD 99999999999999999999 1");
        command("ADD 1 9223372036854775808");
        command("ADD +-1 2");
        command("ADD 1 2-");
        command("ADD 1");
        command("ADD 1 2 3");
        command("ADDX 1 2");
        command({"A", string'(8'd0), "D 1 2"});
        command("MUL 0 -9223372036854775808");
        command("xor 1 2");
        wait_drain();
        for (int n = 0; n < 4; n++)
        begin
            if (n == 3) calm = 1;
            if (n == 2) wait_drain();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(0, 12))
                    send(0, 8'($urandom_range(0, 255)));
                send(1, 8'($urandom));
            end
            else
                command({$urandom_range(0, 1) ? rand_ws() : "", rand_op(), rand_ws(),
                         rand_num($urandom_range(0, 2)), rand_ws(),
                         rand_num($urandom_range(0, 2)),
                         $urandom_range(0, 3) == 0 ? rand_ws() : ""});
        end
        in_ch.valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[files.f]
sv/tcca_pkg.sv
sv/tcca_if.sv
sv/tcca_front.sv
sv/tcca_queue.sv
sv/tcca_back.sv
sv/text_command_checked_alu_core.sv
verif/tcca_checker.sv
verif/tb_top.sv
